@@ rtl/cpdm_pkg.sv @@
// shared types and constants of the capture phase difference meter
package cpdm_pkg;

    localparam int SCALE_WIDTH = 16;                // bits of the full-turn scale factor
    localparam int FULL_TURN = 36000;               // centidegrees in one turn
    localparam int HALF_TURN = 18000;
    localparam int SAT_LIMIT = 54000;               // largest quotient that still folds into range
    localparam logic [31:0] PERIOD_RESET = 32'd240000;

    // edge kind carried in the input tuser
    localparam logic OP_REFERENCE = 1'b0;
    localparam logic OP_MEASURED  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ rtl/cpdm_divider.sv @@
// iterative restoring divider, one quotient bit per cycle
module cpdm_divider #(
    parameter int TIMER_WIDTH = 32
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [TIMER_WIDTH+cpdm_pkg::SCALE_WIDTH-1:0]  dividend,
    input  logic [TIMER_WIDTH-1:0]                        divisor,
    output logic [TIMER_WIDTH+cpdm_pkg::SCALE_WIDTH-1:0]  quotient,
    output cpdm_pkg::div_status_t                         status
);

    localparam int DW = TIMER_WIDTH + cpdm_pkg::SCALE_WIDTH;
    localparam int CW = $clog2(DW + 1);

    logic [TIMER_WIDTH-1:0] rem_reg, rem_next;
    logic [TIMER_WIDTH-1:0] dvs_reg, dvs_next;
    logic [DW-1:0]          quo_reg, quo_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   run_reg, run_next;
    logic                   done_reg, done_next;

    logic [TIMER_WIDTH:0]   shifted;
    logic [TIMER_WIDTH:0]   trial;
    logic                   fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DW-1]};
        trial   = shifted - {1'b0, dvs_reg};
        fits    = !trial[TIMER_WIDTH];

        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next = '0;
            dvs_next = divisor;
            quo_next = dividend;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? trial[TIMER_WIDTH-1:0] : shifted[TIMER_WIDTH-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = run_reg;
    assign status.done = done_reg;

endmodule

@@ rtl/capture_phase_difference_meter.sv @@
// top level of the capture phase difference meter: sequencer, state and result register
// sequence: a reference edge or a zero period goes from ST_IDLE through ST_LOAD to m_tvalid;
//   a measured edge goes through ST_MUL, ST_START, ST_DIV and ST_LOAD, the serial divider
//   retiring one quotient bit per cycle over TIMER_WIDTH + 16 bits
// input: one beat at a time; the next input beat is taken only back in ST_IDLE, and the
//   sequencer waits in ST_LOAD while the output is held
// reset: asynchronous active low; reference time and held phase clear, period returns to 240000
module capture_phase_difference_meter #(
    parameter int TIMER_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // input edge events
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] timestamp
    input  logic [0:0]  s_tuser,    // [0] opcode
    // measurement results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [31:0] period_ticks, [47:32] phase_centideg
    output logic [2:0]  m_tuser     // [0] phase_valid, [1] divide_error, [2] saturated
);

    localparam int DW = TIMER_WIDTH + cpdm_pkg::SCALE_WIDTH;
    localparam int LW = 17;     // enough quotient bits to hold the saturation limit

    cpdm_pkg::state_t state_reg, state_next;

    // timing state
    logic [TIMER_WIDTH-1:0] ref_time_reg, ref_time_next;
    logic [TIMER_WIDTH-1:0] period_reg, period_next;
    logic signed [15:0]     phase_hold_reg, phase_hold_next;

    // working registers of one measured edge
    logic [TIMER_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [DW-1:0]          prod_reg, prod_next;

    // staged result, handed to the output register when it is free
    logic signed [15:0]     res_phase_reg, res_phase_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   res_derr_reg, res_derr_next;
    logic                   res_sat_reg, res_sat_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            out_period_reg, out_period_next;
    logic signed [15:0]     out_phase_reg, out_phase_next;
    logic                   out_pvalid_reg, out_pvalid_next;
    logic                   out_derr_reg, out_derr_next;
    logic                   out_sat_reg, out_sat_next;

    logic                   div_start;
    logic [DW-1:0]          quotient;
    cpdm_pkg::div_status_t  div_st;

    logic                   in_beat;
    logic [TIMER_WIDTH-1:0] ts;
    logic [TIMER_WIDTH-1:0] diff;
    logic                   big;
    logic [LW-1:0]          q_low;
    logic signed [LW:0]     folded;
    logic signed [15:0]     phase_fold;

    cpdm_divider #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (period_reg),
        .quotient (quotient),
        .status   (div_st)
    );

    assign s_tready = (state_reg == cpdm_pkg::ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign ts       = s_tdata[TIMER_WIDTH-1:0];
    // modulo difference from the last reference edge, sign in the top timer bit
    assign diff     = ts - ref_time_reg;

    // fold the magnitude quotient once into one turn, clamp what is left over and restore the sign
    always_comb
    begin
        big   = quotient > DW'(cpdm_pkg::SAT_LIMIT);
        q_low = quotient[LW-1:0];
        if (q_low <= LW'(cpdm_pkg::HALF_TURN))
            folded = signed'({1'b0, q_low});
        else
            folded = signed'({1'b0, q_low}) - signed'((LW+1)'(cpdm_pkg::FULL_TURN));
        if (big)
            phase_fold = neg_reg ? -16'(cpdm_pkg::HALF_TURN) : 16'(cpdm_pkg::HALF_TURN);
        else
            phase_fold = neg_reg ? 16'(-folded) : 16'(folded);
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        ref_time_next   = ref_time_reg;
        period_next     = period_reg;
        phase_hold_next = phase_hold_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        res_phase_next  = res_phase_reg;
        res_valid_next  = res_valid_reg;
        res_derr_next   = res_derr_reg;
        res_sat_next    = res_sat_reg;
        out_valid_next  = out_valid_reg;
        out_period_next = out_period_reg;
        out_phase_next  = out_phase_reg;
        out_pvalid_next = out_pvalid_reg;
        out_derr_next   = out_derr_reg;
        out_sat_next    = out_sat_reg;
        div_start       = 1'b0;

        // result beat taken downstream
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            cpdm_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    res_derr_next = 1'b0;
                    res_sat_next  = 1'b0;
                    if (s_tuser[0] == cpdm_pkg::OP_REFERENCE)
                    begin
                        // new period, phase repeats the held value
                        period_next    = diff;
                        ref_time_next  = ts;
                        res_phase_next = phase_hold_reg;
                        res_valid_next = 1'b0;
                        state_next     = cpdm_pkg::ST_LOAD;
                    end
                    else if (period_reg == '0)
                    begin
                        res_phase_next = '0;
                        res_valid_next = 1'b1;
                        res_derr_next  = 1'b1;
                        state_next     = cpdm_pkg::ST_LOAD;
                    end
                    else
                    begin
                        neg_next       = diff[TIMER_WIDTH-1];
                        mag_next       = diff[TIMER_WIDTH-1] ? -diff : diff;
                        res_valid_next = 1'b1;
                        state_next     = cpdm_pkg::ST_MUL;
                    end
                end
            end
            cpdm_pkg::ST_MUL:
            begin
                prod_next  = DW'(mag_reg) * DW'(cpdm_pkg::FULL_TURN);
                state_next = cpdm_pkg::ST_START;
            end
            cpdm_pkg::ST_START:
            begin
                div_start  = 1'b1;
                state_next = cpdm_pkg::ST_DIV;
            end
            cpdm_pkg::ST_DIV:
            begin
                if (div_st.done)
                begin
                    res_phase_next = phase_fold;
                    res_sat_next   = big;
                    state_next     = cpdm_pkg::ST_LOAD;
                end
            end
            cpdm_pkg::ST_LOAD:
            begin
                // move into the output register once it is free or being emptied
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_period_next = 32'(period_reg);
                    out_phase_next  = res_phase_reg;
                    out_pvalid_next = res_valid_reg;
                    out_derr_next   = res_derr_reg;
                    out_sat_next    = res_sat_reg;
                    phase_hold_next = res_phase_reg;
                    state_next      = cpdm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cpdm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cpdm_pkg::ST_IDLE;
            ref_time_reg   <= '0;
            period_reg     <= cpdm_pkg::PERIOD_RESET[TIMER_WIDTH-1:0];
            phase_hold_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ref_time_reg   <= ref_time_next;
            period_reg     <= period_next;
            phase_hold_reg <= phase_hold_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        prod_reg       <= prod_next;
        res_phase_reg  <= res_phase_next;
        res_valid_reg  <= res_valid_next;
        res_derr_reg   <= res_derr_next;
        res_sat_reg    <= res_sat_next;
        out_period_reg <= out_period_next;
        out_phase_reg  <= out_phase_next;
        out_pvalid_reg <= out_pvalid_next;
        out_derr_reg   <= out_derr_next;
        out_sat_reg    <= out_sat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_phase_reg, out_period_reg};
    assign m_tuser  = {out_sat_reg, out_derr_reg, out_pvalid_reg};

    // the divider never runs while a new edge can be taken
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_st.busy)
        else $error("divider busy while input ready");

    // a finished division is only seen by the sequencer waiting for it
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == cpdm_pkg::ST_DIV))
        else $error("divider done outside of divide wait");

    // a delivered phase always lies within half a turn
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_phase_reg <= 16'sd18000) && (out_phase_reg >= -16'sd18000))
        else $error("phase out of range");

    // error flags only come with a measured edge, and a divide error forces phase zero and no saturation
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_derr_reg || out_sat_reg)) |->
            (out_pvalid_reg && !(out_derr_reg && (out_sat_reg || out_phase_reg != '0))))
        else $error("inconsistent result flags");

endmodule
